// ===== src/humidity_sensor_reading_validator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the humidity sensor reading validator
// Each macro compiles to a concurrent assertion in simulation and to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_READING_VALIDATOR_UNIT_ASSERT_SVH
`define HUMIDITY_SENSOR_READING_VALIDATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define HSRV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsrv: assertion failed");

// checked on every edge, reset included
`define HSRV_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hsrv: reset assertion failed");

`else

`define HSRV_ASSERT(lbl, clk, rst_n, prop)
`define HSRV_ASSERT_RST(lbl, clk, prop)

`endif

`endif

// ===== src/hsrv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsrv_pkg
// Types, constants and helper functions shared by the validator modules.
// ----------------------------------------------------------------------------
package hsrv_pkg;

    // field widths
    localparam int TEMP_W     = 15;
    localparam int HUM_W      = 14;
    localparam int WORD_W     = 16;
    localparam int CHECK_W    = 8;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // CRC-8 parameters
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // conversion constants (hundredths)
    localparam logic [30:0] TEMP_SCALE  = 31'd17500;
    localparam logic [30:0] HUM_SCALE   = 31'd10000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RH_STEP   = 2'd3;

    // configuration reset values
    localparam logic signed [TEMP_W-1:0] RST_MIN_TEMP  = -15'sd2000;
    localparam logic signed [TEMP_W-1:0] RST_MAX_TEMP  = 15'sd6000;
    localparam logic [TEMP_W-1:0]        RST_TEMP_STEP = 15'd1000;
    localparam logic [HUM_W-1:0]         RST_RH_STEP   = 14'd3000;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_ANSWER   = 3'd1,
        ST_CRC_ERROR   = 3'd2,
        ST_IMPLAUSIBLE = 3'd3,
        ST_JUMPED      = 3'd4
    } t_status;

    // configuration register contents
    typedef struct packed {
        logic signed [TEMP_W-1:0] min_temp;
        logic signed [TEMP_W-1:0] max_temp;
        logic [TEMP_W-1:0]        temp_step;
        logic [HUM_W-1:0]         rh_step;
    } t_cfg;

    // converted sensor word
    typedef struct packed {
        logic                     answered;
        logic                     crc_ok;
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
    } t_conv;

    // CRC-8 over a 16-bit word, high byte first
    function automatic logic [7:0] crc8_word(input logic [WORD_W-1:0] word);
        logic [7:0] crc;
        crc = CRC_INIT ^ word[15:8];
        for (int i = 0; i < 8; i++) begin
            crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
        crc = crc ^ word[7:0];
        for (int i = 0; i < 8; i++) begin
            crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
        return crc;
    endfunction

    // floor(x / 65535) for x below 2^31: x = q0*65535 + (lo + q0),
    // the remainder estimate stays under twice the divisor
    function automatic logic [14:0] div_65535(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r0;
        q0 = x[30:16];
        r0 = {1'b0, x[15:0]} + {2'b00, q0};
        return q0 + ((r0 >= 17'd65535) ? 15'd1 : 15'd0);
    endfunction

endpackage

// ===== src/hsrv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hsrv_cfg_regs
// Configuration register file: plausibility limits and step limits.
// ----------------------------------------------------------------------------
module hsrv_cfg_regs
    import hsrv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_TEMP:  n_cfg.min_temp  = i_cfg_data[TEMP_W-1:0];
                CFG_MAX_TEMP:  n_cfg.max_temp  = i_cfg_data[TEMP_W-1:0];
                CFG_TEMP_STEP: n_cfg.temp_step = i_cfg_data[TEMP_W-1:0];
                CFG_RH_STEP:   n_cfg.rh_step   = i_cfg_data[HUM_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_temp  <= RST_MIN_TEMP;
            r_cfg.max_temp  <= RST_MAX_TEMP;
            r_cfg.temp_step <= RST_TEMP_STEP;
            r_cfg.rh_step   <= RST_RH_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/hsrv_conv.sv =====
// ----------------------------------------------------------------------------
// hsrv_conv
// CRC check of both sensor words and conversion to hundredths.
// ----------------------------------------------------------------------------
module hsrv_conv
    import hsrv_pkg::*;
(
    input  logic               i_answered,
    input  logic [WORD_W-1:0]  i_temp_word,
    input  logic [CHECK_W-1:0] i_temp_check,
    input  logic [WORD_W-1:0]  i_hum_word,
    input  logic [CHECK_W-1:0] i_hum_check,
    output t_conv              o_conv
);

    logic [30:0]        temp_prod;
    logic [30:0]        hum_prod;
    logic [14:0]        temp_quo;
    logic [14:0]        hum_quo;
    logic signed [15:0] temp_full;

    // scale: floor(span * raw / 65535)
    assign temp_prod = TEMP_SCALE * {15'd0, i_temp_word};
    assign hum_prod  = HUM_SCALE * {15'd0, i_hum_word};
    assign temp_quo  = div_65535(temp_prod);
    assign hum_quo   = div_65535(hum_prod);

    // temperature offset, result fits in 15 bits signed
    assign temp_full = signed'({1'b0, temp_quo}) - TEMP_OFFSET;

    assign o_conv.answered = i_answered;
    assign o_conv.crc_ok   = (crc8_word(i_temp_word) == i_temp_check) &&
                             (crc8_word(i_hum_word) == i_hum_check);
    assign o_conv.temp     = temp_full[TEMP_W-1:0];
    assign o_conv.hum      = hum_quo[HUM_W-1:0];

endmodule

// ===== src/hsrv_judge.sv =====
// ----------------------------------------------------------------------------
// hsrv_judge
// Validity decision, stored reading, CRC error counter and result register.
// ----------------------------------------------------------------------------
`include "humidity_sensor_reading_validator_unit_assert.svh"

module hsrv_judge
    import hsrv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  t_conv                    i_conv,
    input  t_cfg                     i_cfg,
    input  logic                     i_stall,
    output logic                     o_adv,
    output logic                     o_valid,
    output logic [2:0]               o_status,
    output logic                     o_reading_valid,
    output logic signed [TEMP_W-1:0] o_temperature_centi,
    output logic [HUM_W-1:0]         o_humidity_centi,
    output logic [COUNT_W-1:0]       o_crc_error_count
);

    // stored reading and counter
    logic                     r_have;
    logic signed [TEMP_W-1:0] r_last_temp;
    logic [HUM_W-1:0]         r_last_rh;
    logic [COUNT_W-1:0]       r_crc_total;
    logic                     n_have;
    logic signed [TEMP_W-1:0] n_last_temp;
    logic [HUM_W-1:0]         n_last_rh;
    logic [COUNT_W-1:0]       n_crc_total;

    // result register
    logic                     r_out_valid;
    t_status                  r_status;
    logic                     r_out_have;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic [HUM_W-1:0]         r_out_rh;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     n_out_valid;
    t_status                  n_status;

    logic signed [TEMP_W:0]   temp_diff;
    logic [TEMP_W:0]          temp_dist;
    logic signed [HUM_W:0]    rh_diff;
    logic [HUM_W:0]           rh_dist;
    logic                     out_of_range;
    logic                     jumped;

    // assertion helpers
    logic                     crc_step;
    logic                     rejected;
    logic                     cleared;
    logic [TEMP_W+HUM_W:0]    held_reading;

    // result register frees up when empty or being taken
    assign o_adv = !r_out_valid || !i_stall;

    // distance from the last accepted reading
    assign temp_diff = (TEMP_W+1)'(i_conv.temp) - (TEMP_W+1)'(r_last_temp);
    assign temp_dist = temp_diff[TEMP_W] ? (TEMP_W+1)'(-temp_diff) : temp_diff;
    assign rh_diff   = signed'({1'b0, i_conv.hum}) - signed'({1'b0, r_last_rh});
    assign rh_dist   = rh_diff[HUM_W] ? (HUM_W+1)'(-rh_diff) : rh_diff;

    assign out_of_range = (i_conv.temp < i_cfg.min_temp) || (i_conv.temp > i_cfg.max_temp);
    assign jumped = r_have && ((temp_dist > {1'b0, i_cfg.temp_step}) ||
                               (rh_dist > {1'b0, i_cfg.rh_step}));

    // decision and state update
    always_comb begin
        n_have      = r_have;
        n_last_temp = r_last_temp;
        n_last_rh   = r_last_rh;
        n_crc_total = r_crc_total;
        priority if (!i_conv.answered) begin
            n_status = ST_NO_ANSWER;
        end else if (!i_conv.crc_ok) begin
            n_status    = ST_CRC_ERROR;
            n_crc_total = r_crc_total + COUNT_W'(1);
        end else if (out_of_range) begin
            n_status = ST_IMPLAUSIBLE;
        end else if (jumped) begin
            n_status = ST_JUMPED;
        end else begin
            n_status    = ST_OK;
            n_have      = 1'b1;
            n_last_temp = i_conv.temp;
            n_last_rh   = i_conv.hum;
        end
    end

    // output valid: load on fire, drop when taken
    always_comb begin
        priority if (i_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_last_temp <= '0;
            r_last_rh   <= '0;
            r_crc_total <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_fire) begin
                r_have      <= n_have;
                r_last_temp <= n_last_temp;
                r_last_rh   <= n_last_rh;
                r_crc_total <= n_crc_total;
            end
        end
    end

    // result payload, reports state after the step
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_status    <= n_status;
            r_out_have  <= n_have;
            r_out_temp  <= n_last_temp;
            r_out_rh    <= n_last_rh;
            r_out_count <= n_crc_total;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_status;
    assign o_reading_valid     = r_out_have;
    assign o_temperature_centi = r_out_temp;
    assign o_humidity_centi    = r_out_rh;
    assign o_crc_error_count   = r_out_count;

    assign crc_step     = i_fire && (n_status == ST_CRC_ERROR);
    assign rejected     = i_fire && (n_status != ST_OK);
    assign cleared      = !r_out_valid && !r_have && (r_crc_total == '0);
    assign held_reading = {r_have, r_last_temp, r_last_rh};

    // counter moves by one on a CRC failure and holds otherwise
    `HSRV_ASSERT(a_crc_inc, i_clk, i_rst_n, crc_step |=> r_crc_total == $past(r_crc_total) + 32'd1)
    `HSRV_ASSERT(a_crc_hold, i_clk, i_rst_n, !crc_step |=> $stable(r_crc_total))
    // a rejected answer leaves the stored reading alone
    `HSRV_ASSERT(a_keep_reading, i_clk, i_rst_n, rejected |=> $stable(held_reading))
    // once a reading is held it stays until reset
    `HSRV_ASSERT(a_have_sticky, i_clk, i_rst_n, r_have |=> r_have)
    // reset empties the result register and forgets the reading
    `HSRV_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n |=> cleared)

endmodule

// ===== src/humidity_sensor_reading_validator_unit.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_reading_validator_unit
// Checks sensor answers (CRC-8, plausibility, step limits), converts them to
// hundredths and keeps the last accepted reading.
// ----------------------------------------------------------------------------
// Each word carries an answered flag, a temperature and a humidity word with
// their CRC-8 bytes (polynomial 0x31, init 0xFF). One result word comes back
// per input word, after it has passed the input register and then the result
// register, with CRC, constant scaling and all compares done in the single
// logic stage that lies between those two registers.
// A new word is taken every cycle; the result register decouples the two
// sides so input only stalls when a result is held and the input register is
// full. The result reports status (ok, no answer, crc error, implausible,
// jumped) and the stored reading and CRC error count after that word.
// Configuration writes complete immediately and should only be issued while
// no word is in flight.
// ----------------------------------------------------------------------------
module humidity_sensor_reading_validator_unit
    import hsrv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_answered,
    input  logic [WORD_W-1:0]        i_temp_word,
    input  logic [CHECK_W-1:0]       i_temp_check,
    input  logic [WORD_W-1:0]        i_hum_word,
    input  logic [CHECK_W-1:0]       i_hum_check,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_status,
    output logic                     o_reading_valid,
    output logic signed [TEMP_W-1:0] o_temperature_centi,
    output logic [HUM_W-1:0]         o_humidity_centi,
    output logic [COUNT_W-1:0]       o_crc_error_count,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    logic               r_in_valid;
    logic               r_answered;
    logic [WORD_W-1:0]  r_temp_word;
    logic [CHECK_W-1:0] r_temp_check;
    logic [WORD_W-1:0]  r_hum_word;
    logic [CHECK_W-1:0] r_hum_check;
    logic               n_in_valid;
    logic               in_take;
    logic               adv;
    logic               fire;
    t_cfg               cfg;
    t_conv              conv;

    // handshake of the input register
    assign fire    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;
    assign in_take = i_valid && !o_stall;

    always_comb begin
        priority if (in_take) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_answered   <= i_answered;
            r_temp_word  <= i_temp_word;
            r_temp_check <= i_temp_check;
            r_hum_word   <= i_hum_word;
            r_hum_check  <= i_hum_check;
        end
    end

    hsrv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hsrv_conv u_conv (
        .i_answered   (r_answered),
        .i_temp_word  (r_temp_word),
        .i_temp_check (r_temp_check),
        .i_hum_word   (r_hum_word),
        .i_hum_check  (r_hum_check),
        .o_conv       (conv)
    );

    hsrv_judge u_judge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fire              (fire),
        .i_conv              (conv),
        .i_cfg               (cfg),
        .i_stall             (i_stall),
        .o_adv               (adv),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_reading_valid     (o_reading_valid),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_crc_error_count   (o_crc_error_count)
    );

endmodule
